// ===== rtl/core/shared_array_dual_stack_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shared array dual stack
// Implication checks that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SHARED_ARRAY_DUAL_STACK_ASSERT_SVH
`define SHARED_ARRAY_DUAL_STACK_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SADS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sads: same-cycle check failed");

// next-cycle implication
`define SADS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sads: next-cycle check failed");

`else

`define SADS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SADS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/sads_pkg.sv =====
// ----------------------------------------------------------------------------
// sads_pkg
// Types and constants shared by the dual stack controller and datapath.
// ----------------------------------------------------------------------------
package sads_pkg;

   localparam int FUNC_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 5;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_A = 2'd0,
      FUNC_PUSH_B = 2'd1,
      FUNC_POP_A  = 2'd2,
      FUNC_POP_B  = 2'd3
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_LOAD = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;   // execute the request on the ports this cycle
      logic load;     // move the finished result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free; // output register empty or being drained
   } dp_status_type;

endpackage

// ===== rtl/core/sads_if.sv =====
// ----------------------------------------------------------------------------
// sads_req_if / sads_rsp_if
// Valid/ready channels for stack requests and their responses.
// ----------------------------------------------------------------------------
interface sads_req_if import sads_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output func, output push_value, input ready);
   modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface sads_rsp_if import sads_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] pop_value;
   logic [DEPTH_W-1:0]       depth_a;
   logic [DEPTH_W-1:0]       depth_b;

   modport source (output valid, output status, output pop_value,
                   output depth_a, output depth_b, input ready);
   modport sink   (input valid, input status, input pop_value,
                   input depth_a, input depth_b, output ready);
endinterface

// ===== rtl/core/sads_ctrl.sv =====
// ----------------------------------------------------------------------------
// sads_ctrl
// Two-state sequencer: take a request, then hand its result to the output.
// ----------------------------------------------------------------------------
module sads_ctrl import sads_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_sts,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            // read data is registered now; wait for room at the output
            if (dp_sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/sads_dp.sv =====
// ----------------------------------------------------------------------------
// sads_dp
// Shared store, both stack counts and the response register.
// ----------------------------------------------------------------------------
module sads_dp import sads_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output dp_status_type            dp_sts,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic [DEPTH_W-1:0]       rsp_depth_a,
   output logic [DEPTH_W-1:0]       rsp_depth_b
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SUM_W  = CNT_W + 1;

   // store
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // stack counts
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;

   // pending result of the accepted request
   status_type pend_status_ff, pend_status_in;
   logic       pop_ok_ff, pop_ok_in;

   // output register
   logic                     out_valid_ff;
   status_type               out_status_ff;
   logic signed [DATA_W-1:0] out_pop_ff;
   logic [DEPTH_W-1:0]       out_depth_a_ff;
   logic [DEPTH_W-1:0]       out_depth_b_ff;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SUM_W-1:0]  fill;
   logic              full;
   logic [CNT_W-1:0]  top_b_push, top_b_pop;
   logic [CNT_W+DEPTH_W-1:0] depth_a_ext, depth_b_ext;

   assign fill       = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign full       = fill >= SUM_W'(DEPTH);
   assign top_b_push = CNT_W'(DEPTH - 1) - count_b_ff;
   assign top_b_pop  = CNT_W'(DEPTH) - count_b_ff;

   // operation decode, executed in the accept cycle
   always_comb begin
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      wr_addr        = count_a_ff[ADDR_W-1:0];
      rd_addr        = top_b_pop[ADDR_W-1:0];
      count_a_in     = count_a_ff;
      count_b_in     = count_b_ff;
      pend_status_in = pend_status_ff;
      pop_ok_in      = pop_ok_ff;
      if (cmd.accept) begin
         pend_status_in = ST_DONE;
         pop_ok_in      = 1'b0;
         case (func_type'(req_func))
            FUNC_PUSH_A: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = count_a_ff[ADDR_W-1:0];
                  count_a_in = count_a_ff + 1'b1;
               end
            end
            FUNC_PUSH_B: begin
               if (full) begin
                  pend_status_in = ST_FULL;
               end else begin
                  wr_en      = 1'b1;
                  wr_addr    = top_b_push[ADDR_W-1:0];
                  count_b_in = count_b_ff + 1'b1;
               end
            end
            FUNC_POP_A: begin
               if (count_a_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  count_a_in = count_a_ff - 1'b1;
                  rd_en      = 1'b1;
                  rd_addr    = count_a_in[ADDR_W-1:0];
                  pop_ok_in  = 1'b1;
               end
            end
            default: begin
               if (count_b_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  count_b_in = count_b_ff - 1'b1;
                  rd_en      = 1'b1;
                  rd_addr    = top_b_pop[ADDR_W-1:0];
                  pop_ok_in  = 1'b1;
               end
            end
         endcase
      end
   end

   // store port: one write or one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // counts and pending result
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
      pend_status_ff <= pend_status_in;
      pop_ok_ff      <= pop_ok_in;
   end

   // depths reported on five bits
   assign depth_a_ext = {{DEPTH_W{1'b0}}, count_a_ff};
   assign depth_b_ext = {{DEPTH_W{1'b0}}, count_b_ff};

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         out_status_ff  <= pend_status_ff;
         out_pop_ff     <= pop_ok_ff ? rd_data_ff : '0;
         out_depth_a_ff <= depth_a_ext[DEPTH_W-1:0];
         out_depth_b_ff <= depth_b_ext[DEPTH_W-1:0];
      end
   end

   assign dp_sts.out_free = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_pop_value = out_pop_ff;
   assign rsp_depth_a   = out_depth_a_ff;
   assign rsp_depth_b   = out_depth_b_ff;

endmodule

// ===== rtl/core/shared_array_dual_stack.sv =====
// ----------------------------------------------------------------------------
// shared_array_dual_stack
// Two stacks in one store: A grows up from entry 0, B down from the top.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    func, push_value
//   rsp_ch    out   valid / ready    status, pop_value, depth_a, depth_b
//
// In the accept cycle a request reads or writes the single store port and
// updates the counts; in S_LOAD the registered read data moves into the
// output register once that register has room.
// A new request is taken while the previous response still waits at rsp_ch.
// Synchronous reset clears both counts; the store itself is not cleared.
// ----------------------------------------------------------------------------
`include "shared_array_dual_stack_assert.svh"

module shared_array_dual_stack import sads_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   sads_req_if.sink     req_ch,
   sads_rsp_if.source   rsp_ch
);

   cmd_type       cmd;
   dp_status_type dp_sts;
   logic          req_ready;

   // sequencer
   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .dp_sts    (dp_sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // store, counts and response register
   sads_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_sts         (dp_sts),
      .req_func       (req_ch.func),
      .req_push_value (req_ch.push_value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_status     (rsp_ch.status),
      .rsp_pop_value  (rsp_ch.pop_value),
      .rsp_depth_a    (rsp_ch.depth_a),
      .rsp_depth_b    (rsp_ch.depth_b)
   );

   // one request in flight at a time
   `SADS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_ch.valid && req_ch.ready, !req_ready)
   // a finished result always shows up at the output
   `SADS_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load, rsp_ch.valid)
   // results are only loaded when the output has room
   `SADS_ASSERT_IMPLY(a_load_room, clock, reset, cmd.load, !rsp_ch.valid || rsp_ch.ready)

endmodule
